[rtl/core/assert_macros.svh]
// Concurrent assertion helpers; they compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

[rtl/core/ddq_pkg.sv]
package ddq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } ddq_op_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } ddq_status_t;

  localparam logic signed [31:0] EMPTY_WORD = -32'sd1000;

  typedef struct packed {
    ddq_op_t            op;
    logic signed [31:0] value;
  } ddq_req_t;

  typedef struct packed {
    logic signed [31:0] front_word;
    logic signed [31:0] back_word;
    logic [4:0]         count;
    ddq_status_t        status;
  } ddq_rsp_t;

endpackage

[rtl/core/ddq_ram.sv]
// Word store: one write port, two read ports, registered read data.
module ddq_ram #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic signed [31:0]               wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr_a,
  input  logic [$clog2(DEPTH)-1:0]         raddr_b,
  output logic signed [31:0]               rdata_a,
  output logic signed [31:0]               rdata_b
);
  import ddq_pkg::*;

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[rtl/core/double_ended_queue_top.sv]
// Bounded double-ended queue of signed 32-bit words in a ring of DEPTH slots.
// Request channel (req_valid/req_ready/req): one beat carries an operation
// (push back, push front, pop front, pop back) and the word to push.
// Response channel (rsp_valid/rsp_ready/rsp): one beat per request with the
// front word, back word, count and status after the operation. Both words
// read -1000 when the queue is empty. A push on a full queue is dropped with
// status 2; a pop on an empty queue is ignored with status 1.
// Each request runs update/write, synchronous memory read of the front
// and back slots (ST_READ) and response load (ST_LOAD); no new request is
// taken until the current one is back in ST_IDLE.
// The response sits in an output register, so the next request is taken
// while a response waits; if the receiver stalls, the following response
// is held back until the register frees and no new request is taken then.
// Reset (rst, synchronous) empties the queue and drops any pending
// response; the slot memory itself is not cleared.
module double_ended_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  ddq_pkg::ddq_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output ddq_pkg::ddq_rsp_t rsp
);
  import ddq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  state_t         state, state_next;
  logic [AW-1:0]  head, head_next;
  logic [AW-1:0]  tail, tail_next;
  logic [CW-1:0]  count, count_next;
  ddq_status_t    status_q, status_next;

  logic              accept;
  logic              is_push;
  logic              full;
  logic              empty;
  logic              load_ok;
  logic [AW-1:0]     head_inc, head_dec, tail_inc, tail_dec;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic signed [31:0] rd_front, rd_back;
  logic [CW+4:0]     count_ext;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign is_push   = (req.op == OP_PUSH_BACK) || (req.op == OP_PUSH_FRONT);
  assign full      = (count == FULL_COUNT);
  assign empty     = (count == '0);
  assign load_ok   = !rsp_valid || rsp_ready;
  assign count_ext = {5'b0, count};

  assign head_inc = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? LAST_SLOT : head - 1'b1;
  assign tail_inc = (tail == LAST_SLOT) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? LAST_SLOT : tail - 1'b1;

  // Pointer/count update for the request on the port
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    status_next = STAT_DONE;
    wr_en       = 1'b0;
    wr_addr     = tail;
    unique case (req.op)
      OP_PUSH_BACK: begin
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = tail;
          tail_next  = tail_inc;
          count_next = count + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = head_dec;
          head_next  = head_dec;
          count_next = count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_next = STAT_EMPTY;
        end else begin
          head_next  = head_inc;
          count_next = count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_next = STAT_EMPTY;
        end else begin
          tail_next  = tail_dec;
          count_next = count - 1'b1;
        end
      end
      default: begin
        status_next = STAT_DONE;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_READ;
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: if (load_ok) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Reads happen in ST_READ, after the write has landed, so no forwarding needed.
  ddq_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (accept && wr_en),
    .waddr   (wr_addr),
    .wdata   (req.value),
    .re      (state == ST_READ),
    .raddr_a (head),
    .raddr_b (tail_dec),
    .rdata_a (rd_front),
    .rdata_b (rd_back)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      status_q  <= STAT_DONE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        head     <= head_next;
        tail     <= tail_next;
        count    <= count_next;
        status_q <= status_next;
      end
      if (state == ST_LOAD && load_ok) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && load_ok) begin
      rsp.front_word <= empty ? EMPTY_WORD : rd_front;
      rsp.back_word  <= empty ? EMPTY_WORD : rd_back;
      rsp.count      <= count_ext[4:0];
      rsp.status     <= status_q;
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEVER(a_count_bound, clk, rst, count > FULL_COUNT, "count above depth")
  `ASSERT_CLK(a_full_push_holds, clk, rst, (accept && is_push && full) |=> ($stable(count) && $stable(head) && $stable(tail)), "push on full changed state")
  `ASSERT_CLK(a_rsp_from_load, clk, rst, $rose(rsp_valid) |-> $past(state == ST_LOAD), "response raised outside load")
  `ASSERT_CLK(a_empty_words, clk, rst, (state == ST_LOAD && load_ok && empty) |=> (rsp.front_word == EMPTY_WORD && rsp.back_word == EMPTY_WORD), "empty queue words wrong")

endmodule
